### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define HJS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define HJS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hjs_pkg.sv
package hjs_pkg;

    localparam int MAX_SIDE       = 64;
    localparam int TEMP_BITS      = 16;
    localparam int ROW_BITS       = $clog2(MAX_SIDE);
    localparam int SIDE_BITS      = ROW_BITS + 1;
    localparam int CELL_BITS      = 2 * ROW_BITS;
    localparam int CELLS          = MAX_SIDE * MAX_SIDE;
    localparam int GRID_ADDR_BITS = CELL_BITS + 1;
    localparam int LINE_LEN       = 2 * MAX_SIDE;
    localparam int IO_TEMP_BITS   = 16;
    localparam int COORD_BITS     = 6;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int SIDE_CFG_BITS  = 7;

    typedef logic signed [TEMP_BITS-1:0]    temp_t;
    typedef logic signed [IO_TEMP_BITS-1:0] io_temp_t;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_SWEEP = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_SIDE    = 2'd0,
        CFG_INITIAL_TEMP = 2'd1,
        CFG_WALL_TEMP    = 2'd2,
        CFG_FIRE_TEMP    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        act_t                  action;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        io_temp_t              cell_temp;
        logic                  cell_fire;
    } in_t;

    typedef struct packed {
        io_temp_t read_temp;
        logic     read_fire;
        logic     status;
    } out_t;

    typedef struct packed {
        logic shift;
        logic border;
        logic fire;
    } stn_ctrl_t;

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_CLEAR     = 8'b0000_0010,
        ST_SWEEP     = 8'b0000_0100,
        ST_SWEEP_END = 8'b0000_1000,
        ST_WRITE     = 8'b0001_0000,
        ST_READ      = 8'b0010_0000,
        ST_READ_WAIT = 8'b0100_0000,
        ST_FINISH    = 8'b1000_0000
    } state_t;

endpackage

### rtl/core/hjs_ram.sv
module hjs_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/hjs_stencil.sv
module hjs_stencil
    import hjs_pkg::*;
(
    input  logic      clk,
    input  stn_ctrl_t ctrl,
    input  temp_t     din,
    input  temp_t     wall,
    input  temp_t     fire_val,
    output temp_t     value
);

    // The line holds the two previous grid rows, newest entry first.
    temp_t                   line_reg [LINE_LEN];
    logic signed [TEMP_BITS+1:0] sum;
    temp_t                   mean;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            line_reg[0] <= din;
            for (int j = 1; j < LINE_LEN; j++)
            begin
                line_reg[j] <= line_reg[j-1];
            end
        end
    end

    always_comb
    begin
        sum = (TEMP_BITS+2)'(line_reg[LINE_LEN-1])
            + (TEMP_BITS+2)'(line_reg[MAX_SIDE])
            + (TEMP_BITS+2)'(line_reg[MAX_SIDE-2])
            + (TEMP_BITS+2)'(din);
        mean = sum[TEMP_BITS+1:2];
        if (ctrl.fire)
        begin
            value = fire_val;
        end
        else if (ctrl.border)
        begin
            value = wall;
        end
        else
        begin
            value = mean;
        end
    end

endmodule

### rtl/core/heat_jacobi_stencil_grid.sv
// Clear: one cell per cycle over the whole current store, writing only the cells inside the
// grid, which also empties the fire mask. Sweep: the current store streamed once through a
// two-row line buffer at one cell per cycle. One request is in work at a time; a finished
// result waits in the output register. Reset clears control state and loads the register
// reset values; the grid stores and the fire mask are undefined until clear or write, and no
// clearing pass runs after reset.
`include "assert_macros.svh"

module heat_jacobi_stencil_grid
    import hjs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_t                      in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_t                     out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    state_t                   state_reg, state_next;
    logic [CELL_BITS:0]       k_reg, k_next;
    logic                     s1_valid_reg, s1_valid_next;
    logic [CELL_BITS:0]       s1_k_reg, s1_k_next;
    logic                     sel_reg, sel_next;
    in_t                      item_reg, item_next;
    out_t                     res_reg, res_next;
    logic                     out_valid_reg, out_valid_next;
    out_t                     out_reg, out_next;

    logic [SIDE_CFG_BITS-1:0] grid_side_reg;
    io_temp_t                 initial_temp_reg;
    io_temp_t                 wall_temp_reg;
    io_temp_t                 fire_temp_reg;

    logic [SIDE_BITS-1:0]     side;
    logic [SIDE_BITS-1:0]     side_m1;
    temp_t                    wall_s, init_s, fire_s;

    logic                     g_we;
    logic [GRID_ADDR_BITS-1:0] g_waddr, g_raddr;
    temp_t                    g_wdata, g_rdata;
    logic                     f_we, f_wdata, f_rdata;
    logic [CELL_BITS-1:0]     f_waddr, f_raddr;

    logic [ROW_BITS-1:0]      cl_row, cl_col;
    logic                     cl_border;
    logic [CELL_BITS:0]       ck;
    logic [SIDE_BITS-1:0]     c_row;
    logic [ROW_BITS-1:0]      c_col;
    logic                     c_active;
    logic                     in_range;
    logic [CELL_BITS-1:0]     cell_addr;
    logic [CELL_BITS:0]       sweep_last;
    stn_ctrl_t                stn_ctrl;
    temp_t                    stn_value;

    always_comb
    begin
        if (grid_side_reg < SIDE_CFG_BITS'(3))
        begin
            side = SIDE_BITS'(3);
        end
        else if (grid_side_reg > SIDE_CFG_BITS'(MAX_SIDE))
        begin
            side = SIDE_BITS'(MAX_SIDE);
        end
        else
        begin
            side = SIDE_BITS'(grid_side_reg);
        end
    end

    assign side_m1    = side - SIDE_BITS'(1);
    assign wall_s     = TEMP_BITS'(wall_temp_reg);
    assign init_s     = TEMP_BITS'(initial_temp_reg);
    assign fire_s     = TEMP_BITS'(fire_temp_reg);
    assign sweep_last = {side, {ROW_BITS{1'b1}}};

    assign cl_row    = k_reg[CELL_BITS-1:ROW_BITS];
    assign cl_col    = k_reg[ROW_BITS-1:0];
    assign cl_border = (cl_row == '0) || (cl_col == '0) ||
                       (SIDE_BITS'(cl_row) == side_m1) || (SIDE_BITS'(cl_col) == side_m1);

    // The centre cell trails the read pointer by one row; an underflow lands outside the grid.
    assign ck       = s1_k_reg - (CELL_BITS+1)'(MAX_SIDE);
    assign c_row    = ck[CELL_BITS:ROW_BITS];
    assign c_col    = ck[ROW_BITS-1:0];
    assign c_active = (c_row < side) && (SIDE_BITS'(c_col) < side);

    assign in_range  = (SIDE_BITS'(item_reg.row) < side) && (SIDE_BITS'(item_reg.col) < side);
    assign cell_addr = {ROW_BITS'(item_reg.row), ROW_BITS'(item_reg.col)};

    assign stn_ctrl.shift  = s1_valid_reg;
    assign stn_ctrl.border = (c_row == '0) || (c_col == '0) ||
                             (c_row == side_m1) || (SIDE_BITS'(c_col) == side_m1);
    assign stn_ctrl.fire   = f_rdata;

    hjs_ram #(
        .ADDR_BITS (GRID_ADDR_BITS),
        .DATA_BITS (TEMP_BITS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    hjs_ram #(
        .ADDR_BITS (CELL_BITS),
        .DATA_BITS (1)
    ) u_fire_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    hjs_stencil u_stencil (
        .clk      (clk),
        .ctrl     (stn_ctrl),
        .din      (g_rdata),
        .wall     (wall_s),
        .fire_val (fire_s),
        .value    (stn_value)
    );

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        s1_valid_next = 1'b0;
        s1_k_next     = s1_k_reg;
        sel_next      = sel_reg;
        item_next     = item_reg;
        res_next      = res_reg;
        g_we          = 1'b0;
        g_waddr       = {sel_reg, k_reg[CELL_BITS-1:0]};
        g_wdata       = init_s;
        g_raddr       = {sel_reg, k_reg[CELL_BITS-1:0]};
        f_we          = 1'b0;
        f_waddr       = k_reg[CELL_BITS-1:0];
        f_wdata       = 1'b0;
        f_raddr       = k_reg[CELL_BITS-1:0] - CELL_BITS'(MAX_SIDE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    res_next  = '0;
                    k_next    = '0;
                    case (in_data.action)
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_WRITE: state_next = ST_WRITE;
                        ACT_SWEEP: state_next = ST_SWEEP;
                        default:   state_next = ST_READ;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                g_we    = (SIDE_BITS'(cl_row) < side) && (SIDE_BITS'(cl_col) < side);
                g_wdata = cl_border ? wall_s : init_s;
                f_we    = 1'b1;
                k_next  = k_reg + (CELL_BITS+1)'(1);
                if (k_reg[CELL_BITS-1:0] == CELL_BITS'(CELLS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SWEEP:
            begin
                s1_valid_next = 1'b1;
                s1_k_next     = k_reg;
                k_next        = k_reg + (CELL_BITS+1)'(1);
                if (k_reg == sweep_last)
                begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END:
            begin
                sel_next   = ~sel_reg;
                state_next = ST_FINISH;
            end
            ST_WRITE:
            begin
                if (in_range)
                begin
                    g_we    = 1'b1;
                    g_waddr = {sel_reg, cell_addr};
                    g_wdata = TEMP_BITS'(item_reg.cell_temp);
                    f_we    = 1'b1;
                    f_waddr = cell_addr;
                    f_wdata = item_reg.cell_fire;
                end
                else
                begin
                    res_next.status = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_READ:
            begin
                g_raddr = {sel_reg, cell_addr};
                f_raddr = cell_addr;
                if (in_range)
                begin
                    state_next = ST_READ_WAIT;
                end
                else
                begin
                    res_next.status = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_READ_WAIT:
            begin
                res_next.read_temp = IO_TEMP_BITS'(g_rdata);
                res_next.read_fire = f_rdata;
                state_next         = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (s1_valid_reg && c_active)
        begin
            g_we    = 1'b1;
            g_waddr = {~sel_reg, ck[CELL_BITS-1:0]};
            g_wdata = stn_value;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (state_reg == ST_FINISH && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            out_next       = res_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s1_k_reg      <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            s1_k_reg      <= s1_k_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg    <= SIDE_CFG_BITS'(MAX_SIDE);
            initial_temp_reg <= '0;
            wall_temp_reg    <= '0;
            fire_temp_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GRID_SIDE:    grid_side_reg    <= cfg_data[SIDE_CFG_BITS-1:0];
                CFG_INITIAL_TEMP: initial_temp_reg <= cfg_data;
                CFG_WALL_TEMP:    wall_temp_reg    <= cfg_data;
                CFG_FIRE_TEMP:    fire_temp_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    `HJS_ASSERT_NEXT(a_finish_delivers, (state_reg == ST_FINISH) && !(out_valid_reg && out_stall), out_valid_reg && (state_reg == ST_IDLE), "Finished request was not delivered.")
    `HJS_ASSERT_IMPL(a_sweep_writes_next, s1_valid_reg && g_we, g_waddr[GRID_ADDR_BITS-1] != sel_reg, "Sweep wrote into the current store.")
    `HJS_ASSERT_IMPL(a_select_toggle, sel_reg != $past(sel_reg), $past(state_reg) == ST_SWEEP_END, "Store select changed outside the end of a sweep.")

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import hjs_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 300;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    in_t                      in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    out_t                     out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index = CFG_GRID_SIDE;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    heat_jacobi_stencil_grid uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    temp_t                    heat_store [2][CELLS];
    logic                     flame_mask [CELLS];
    bit                       live_sel = 1'b0;
    logic [SIDE_CFG_BITS-1:0] side_cfg = 7'd64;
    temp_t                    initial_cfg = '0;
    temp_t                    wall_cfg = '0;
    temp_t                    fire_cfg = '0;

    // Which entries the requests queued so far will have set, so that no request
    // ever reads a cell or sweeps over a neighbour that was never written.
    bit                       cell_set [2][CELLS];
    bit                       mask_set [CELLS];
    bit                       plan_sel = 1'b0;

    in_t                      request_backlog [$];
    out_t                     due_readings [$];

    int                       act_tally [4];
    int                       off_grid_count = 0;
    int                       settings_count = 0;
    int                       readings_checked = 0;
    int                       fault_count = 0;
    int                       idle_cycles = 0;
    int                       in_taken = 0;
    int                       gap_left = 0;
    int                       burst_left = 0;
    int                       hold_left = 0;
    bit                       long_hold_done = 1'b0;
    int                       window_left = 0;
    int                       stall_pct = 0;

    function automatic int active_side();
        if (side_cfg < 3)
            return 3;
        if (side_cfg > MAX_SIDE)
            return MAX_SIDE;
        return int'(side_cfg);
    endfunction

    function automatic out_t predict_heat_result(in_t req);
        out_t  res;
        int    n;
        int    r;
        int    c;
        int    idx;
        int    sum;
        temp_t next_val;
        res = '0;
        n = active_side();
        case (req.action)
            ACT_CLEAR:
            begin
                for (r = 0; r < n; r++)
                begin
                    for (c = 0; c < n; c++)
                    begin
                        if (r == 0 || c == 0 || r == n - 1 || c == n - 1)
                            heat_store[live_sel][r * MAX_SIDE + c] = wall_cfg;
                        else
                            heat_store[live_sel][r * MAX_SIDE + c] = initial_cfg;
                    end
                end
                for (idx = 0; idx < CELLS; idx++)
                    flame_mask[idx] = 1'b0;
            end
            ACT_SWEEP:
            begin
                for (r = 0; r < n; r++)
                begin
                    for (c = 0; c < n; c++)
                    begin
                        idx = r * MAX_SIDE + c;
                        if (r == 0 || c == 0 || r == n - 1 || c == n - 1)
                            next_val = wall_cfg;
                        else
                        begin
                            sum = int'(heat_store[live_sel][idx - MAX_SIDE])
                                + int'(heat_store[live_sel][idx + MAX_SIDE])
                                + int'(heat_store[live_sel][idx - 1])
                                + int'(heat_store[live_sel][idx + 1]);
                            next_val = temp_t'(sum >>> 2);
                        end
                        if (flame_mask[idx])
                            next_val = fire_cfg;
                        heat_store[~live_sel][idx] = next_val;
                    end
                end
                live_sel = ~live_sel;
            end
            default:
            begin
                if (req.row >= n || req.col >= n)
                begin
                    res.status = 1'b1;
                    off_grid_count++;
                end
                else
                begin
                    idx = req.row * MAX_SIDE + req.col;
                    if (req.action == ACT_WRITE)
                    begin
                        heat_store[live_sel][idx] = req.cell_temp;
                        flame_mask[idx] = req.cell_fire;
                    end
                    else
                    begin
                        res.read_temp = heat_store[live_sel][idx];
                        res.read_fire = flame_mask[idx];
                    end
                end
            end
        endcase
        return res;
    endfunction

    function automatic void queue_request(in_t req);
        int n;
        int r;
        int c;
        int k;
        int idx;
        bit whole;
        n = active_side();
        idx = req.row * MAX_SIDE + req.col;
        if (req.action == ACT_SWEEP)
        begin
            whole = 1'b1;
            for (r = 0; r < n; r++)
            begin
                for (c = 0; c < n; c++)
                begin
                    k = r * MAX_SIDE + c;
                    if (!cell_set[plan_sel][k] || !mask_set[k])
                        whole = 1'b0;
                end
            end
            if (!whole)
                req.action = ACT_CLEAR;
        end
        else if (req.action == ACT_READ && req.row < n && req.col < n
                 && !(cell_set[plan_sel][idx] && mask_set[idx]))
            req.action = ACT_WRITE;
        case (req.action)
            ACT_CLEAR:
            begin
                for (r = 0; r < n; r++)
                begin
                    for (c = 0; c < n; c++)
                        cell_set[plan_sel][r * MAX_SIDE + c] = 1'b1;
                end
                for (k = 0; k < CELLS; k++)
                    mask_set[k] = 1'b1;
            end
            ACT_SWEEP:
            begin
                for (r = 0; r < n; r++)
                begin
                    for (c = 0; c < n; c++)
                        cell_set[~plan_sel][r * MAX_SIDE + c] = 1'b1;
                end
                plan_sel = ~plan_sel;
            end
            ACT_WRITE:
            begin
                if (req.row < n && req.col < n)
                begin
                    cell_set[plan_sel][idx] = 1'b1;
                    mask_set[idx] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        request_backlog.push_back(req);
    endfunction

    function automatic in_t make_request(act_t act, int r, int c,
                                         logic [IO_TEMP_BITS-1:0] t, logic f);
        in_t req;
        req.action = act;
        req.row = 6'(r);
        req.col = 6'(c);
        req.cell_temp = t;
        req.cell_fire = f;
        return req;
    endfunction

    function automatic logic [IO_TEMP_BITS-1:0] pick_temp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_t random_request();
        in_t req;
        int  n;
        int  pick;
        n = active_side();
        req.row = 6'($urandom_range(0, 63));
        req.col = 6'($urandom_range(0, 63));
        req.cell_temp = pick_temp();
        req.cell_fire = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 6)
            req.action = ACT_CLEAR;
        else if (pick < 18)
            req.action = ACT_SWEEP;
        else if (pick < 55)
            req.action = ACT_WRITE;
        else
            req.action = ACT_READ;
        if ((req.action == ACT_WRITE || req.action == ACT_READ) && $urandom_range(0, 9) != 0)
        begin
            req.row = 6'($urandom_range(0, n - 1));
            req.col = 6'($urandom_range(0, n - 1));
        end
        return req;
    endfunction

    task automatic log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    task automatic write_setting(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_GRID_SIDE:    side_cfg = val[SIDE_CFG_BITS-1:0];
            CFG_INITIAL_TEMP: initial_cfg = val;
            CFG_WALL_TEMP:    wall_cfg = val;
            CFG_FIRE_TEMP:    fire_cfg = val;
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_settings(logic [SIDE_CFG_BITS-1:0] side,
                                  logic [CFG_DATA_BITS-1:0] init_t,
                                  logic [CFG_DATA_BITS-1:0] wall_t,
                                  logic [CFG_DATA_BITS-1:0] fire_t);
        write_setting(CFG_GRID_SIDE, {9'b0, side});
        write_setting(CFG_INITIAL_TEMP, init_t);
        write_setting(CFG_WALL_TEMP, wall_t);
        write_setting(CFG_FIRE_TEMP, fire_t);
        settings_count++;
    endtask

    // Sampled on the falling edge so that the queues and the valid are settled.
    task automatic wait_for_quiet();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || in_valid || due_readings.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_requests
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                due_readings.push_back(predict_heat_result(in_data));
                act_tally[int'(in_data.action)]++;
                in_taken++;
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0 || request_backlog.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_backlog.pop_front();
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                                 : $urandom_range(0, 5);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : pace_receiver
        if (rst_n)
        begin
            if (!long_hold_done && in_taken >= 6)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (window_left == 0)
            begin
                window_left = $urandom_range(8, 48);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 70;
                endcase
            end
            else
                window_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_readings
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_readings.size() == 0)
                log_fault($sformatf("Unexpected result: temp %h fire %b status %b",
                                    out_data.read_temp, out_data.read_fire, out_data.status));
            else
            begin
                want = due_readings.pop_front();
                readings_checked++;
                if (out_data.read_temp !== want.read_temp
                    || out_data.read_fire !== want.read_fire
                    || out_data.status !== want.status)
                    log_fault($sformatf(
                        "Result %0d mismatch: expected temp %h fire %b status %b, got %h %b %b",
                        readings_checked, want.read_temp, want.read_fire, want.status,
                        out_data.read_temp, out_data.read_fire, out_data.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("No request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int phase_len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_quiet();

        // A grid of side five, with the initial and wall temperatures at opposite extremes.
        apply_settings(7'd5, 16'h7FFF, 16'h8000, 16'h0180);
        queue_request(make_request(ACT_CLEAR, 63, 63, 16'hFFFF, 1'b1));
        queue_request(make_request(ACT_READ, 0, 0, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 2, 2, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 4, 4, 16'h0000, 1'b0));
        queue_request(make_request(ACT_WRITE, 1, 1, 16'h8000, 1'b0));
        queue_request(make_request(ACT_WRITE, 0, 2, 16'h1234, 1'b1));
        queue_request(make_request(ACT_WRITE, 3, 3, 16'h7FFF, 1'b1));
        queue_request(make_request(ACT_WRITE, 2, 3, 16'hFFFF, 1'b0));
        queue_request(make_request(ACT_READ, 5, 0, 16'h0000, 1'b0));
        queue_request(make_request(ACT_WRITE, 0, 5, 16'h4321, 1'b1));
        queue_request(make_request(ACT_READ, 63, 63, 16'h0000, 1'b0));
        queue_request(make_request(ACT_WRITE, 63, 0, 16'h5555, 1'b1));
        queue_request(make_request(ACT_READ, 0, 2, 16'h0000, 1'b0));
        queue_request(make_request(ACT_SWEEP, 0, 0, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 0, 2, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 2, 2, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 1, 1, 16'h0000, 1'b0));
        queue_request(make_request(ACT_SWEEP, 42, 21, 16'hAAAA, 1'b1));
        queue_request(make_request(ACT_READ, 2, 3, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 3, 3, 16'h0000, 1'b0));
        queue_request(make_request(ACT_CLEAR, 0, 0, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 3, 3, 16'h0000, 1'b0));
        queue_request(make_request(ACT_SWEEP, 0, 0, 16'h0000, 1'b0));
        queue_request(make_request(ACT_READ, 1, 2, 16'h0000, 1'b0));

        for (phase = 0; phase < 6; phase++)
        begin
            wait_for_quiet();
            case (phase)
                0: apply_settings(7'd0, pick_temp(), pick_temp(), pick_temp());
                1: apply_settings(7'd127, 16'h8000, 16'h7FFF, 16'h8000);
                2: apply_settings(7'($urandom_range(3, 12)), pick_temp(), pick_temp(),
                                  pick_temp());
                3: apply_settings(7'd64, 16'h7FFF, 16'h7FFF, 16'h0000);
                4: apply_settings(7'd3, pick_temp(), pick_temp(), pick_temp());
                default: apply_settings(7'($urandom_range(1, 20)), pick_temp(), pick_temp(),
                                        pick_temp());
            endcase
            phase_len = (phase == 2 || phase == 5) ? 26 : 16;
            repeat (phase_len) queue_request(random_request());
        end

        wait_for_quiet();
        repeat (16) @(posedge clk);
        $display("Requests: %0d clear, %0d write, %0d sweep, %0d read; %0d outside the grid.",
                 act_tally[ACT_CLEAR], act_tally[ACT_WRITE], act_tally[ACT_SWEEP],
                 act_tally[ACT_READ], off_grid_count);
        $display("Checked %0d results under %0d register settings; %0d mismatches.",
                 readings_checked, settings_count, fault_count);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
